FILE: rtl/lfa_pkg.sv
// ----------------------------------------------------------------------------
// lfa_pkg
// Shared types and codes of the lowest free ID allocator.
// ----------------------------------------------------------------------------
package lfa_pkg;

	localparam logic KIND_ALLOC = 1'b0;
	localparam logic KIND_FREE  = 1'b1;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_EXHAUSTED = 2'd1;
	localparam logic [1:0] ST_IGNORED   = 2'd2;

	typedef struct packed {
		logic       kind;
		logic [7:0] release_id;
	} req_t;

	typedef struct packed {
		logic [7:0] granted_id;
		logic [1:0] status;
	} rsp_t;

	typedef struct packed {
		logic load;
		logic step;
		logic finish;
	} cmd_t;

	typedef struct packed {
		logic is_alloc;
		logic word_nz;
		logic ptr_last;
	} sts_t;

endpackage

FILE: rtl/lfa_datapath.sv
// ----------------------------------------------------------------------------
// lfa_datapath
// Freed-ID bitmap in 32-bit words, watermark, word pointer and result register.
// ----------------------------------------------------------------------------
module lfa_datapath #(
	parameter int NUM_IDS = 256
) (
	input  logic          clk,
	input  logic          arst_n,
	input  lfa_pkg::req_t req,
	input  lfa_pkg::cmd_t cmd,
	output lfa_pkg::sts_t sts,
	output lfa_pkg::rsp_t rsp
);
	import lfa_pkg::*;

	localparam int MAP_IDS   = (NUM_IDS < 256) ? NUM_IDS : 256;
	localparam int MAP_WORDS = (MAP_IDS + 31) / 32;
	localparam int PTR_W     = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
	localparam int WM_W      = $clog2(NUM_IDS + 1);
	localparam int CMP_W     = (WM_W > 8) ? WM_W : 8;
	localparam int FID_W     = PTR_W + 5;

	logic [31:0]      map_q [MAP_WORDS];
	logic [WM_W-1:0]  wm_q;
	logic [PTR_W-1:0] ptr_q;
	logic             kind_q;
	logic [7:0]       rid_q;
	rsp_t             rsp_q;

	logic [31:0]      word;
	logic [4:0]       lb;
	logic [FID_W-1:0] found_id;
	logic [CMP_W-1:0] rid_c;
	logic [CMP_W-1:0] wm_c;
	logic [31:0]      rid_mask;
	logic             map_we;
	logic [31:0]      map_wd;
	logic [WM_W-1:0]  wm_d;
	rsp_t             rsp_d;

	assign word     = (int'(ptr_q) < MAP_WORDS) ? map_q[ptr_q] : '0;
	assign found_id = {ptr_q, lb};
	assign rid_c    = CMP_W'(rid_q);
	assign wm_c     = CMP_W'(wm_q);
	assign rid_mask = 32'd1 << rid_q[4:0];

	always_comb begin
		lb = '0;
		for (int i = 31; i >= 0; i--) begin
			if (word[i]) begin
				lb = 5'(i);
			end
		end
	end

	assign sts.is_alloc = (kind_q == KIND_ALLOC);
	assign sts.word_nz  = (word != '0);
	assign sts.ptr_last = (ptr_q == PTR_W'(MAP_WORDS - 1));

	always_comb begin
		map_we = 1'b0;
		map_wd = word;
		wm_d   = wm_q;
		rsp_d  = '{granted_id: 8'd0, status: ST_OK};
		if (kind_q == KIND_ALLOC) begin
			if (word != '0) begin
				map_we           = 1'b1;
				map_wd           = word & ~(32'd1 << lb);
				rsp_d.granted_id = 8'(found_id);
			end else if (wm_q != WM_W'(NUM_IDS)) begin
				wm_d             = wm_q + WM_W'(1);
				rsp_d.granted_id = 8'(wm_q);
			end else begin
				rsp_d.status = ST_EXHAUSTED;
			end
		end else begin
			if (rid_c >= wm_c) begin
				rsp_d.status = ST_IGNORED;
			end else if (rid_c == wm_c - CMP_W'(1)) begin
				wm_d   = wm_q - WM_W'(1);
				map_we = 1'b1;
				map_wd = word & ~rid_mask;
			end else begin
				map_we = 1'b1;
				map_wd = word | rid_mask;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAP_WORDS; i++) begin
				map_q[i] <= '0;
			end
			wm_q <= '0;
		end else if (cmd.finish) begin
			if (map_we) begin
				map_q[ptr_q] <= map_wd;
			end
			wm_q <= wm_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q  <= '0;
			kind_q <= KIND_ALLOC;
		end else if (cmd.load) begin
			kind_q <= req.kind;
			ptr_q  <= (req.kind == KIND_ALLOC) ? '0 : PTR_W'(req.release_id[7:5]);
		end else if (cmd.step) begin
			ptr_q <= ptr_q + PTR_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			rid_q <= req.release_id;
		end
		if (cmd.finish) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp = rsp_q;

	a_wm_range: assert property (@(posedge clk) disable iff (!arst_n)
		int'(wm_q) <= NUM_IDS)
		else $error("watermark beyond id range");

	a_step_alloc: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.step |-> (sts.is_alloc && !sts.word_nz && !sts.ptr_last))
		else $error("scan advanced past a usable word");

	a_reuse_wm: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.finish && sts.is_alloc && sts.word_nz) |=> $stable(wm_q))
		else $error("watermark moved on reuse of a freed id");

endmodule

FILE: rtl/lfa_ctrl.sv
// ----------------------------------------------------------------------------
// lfa_ctrl
// Request sequencer: accept, scan the map, commit and fill the result slot.
// ----------------------------------------------------------------------------
module lfa_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	input  lfa_pkg::sts_t sts,
	output lfa_pkg::cmd_t cmd
);
	import lfa_pkg::*;

	localparam logic S_IDLE = 1'b0;
	localparam logic S_EXEC = 1'b1;

	logic state_q;
	logic rsp_valid_q;
	logic slot_free;
	logic done;

	assign slot_free = !rsp_valid_q || rsp_ready;
	assign done      = !sts.is_alloc || sts.word_nz || sts.ptr_last;

	assign req_ready  = (state_q == S_IDLE);
	assign cmd.load   = req_valid && req_ready;
	assign cmd.step   = (state_q == S_EXEC) && !done;
	assign cmd.finish = (state_q == S_EXEC) && done && slot_free;
	assign rsp_valid  = rsp_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (cmd.load) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					if (cmd.finish) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
			if (cmd.finish) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	a_finish_out: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |=> (rsp_valid_q && state_q == S_IDLE))
		else $error("finished request not presented");

	a_hold_exec: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EXEC && !cmd.finish) |=> (state_q == S_EXEC))
		else $error("request dropped before commit");

endmodule

FILE: rtl/lowest_free_id_allocator.sv
// ----------------------------------------------------------------------------
// lowest_free_id_allocator
// Allocates the lowest freed ID or the watermark; takes IDs back.
// ----------------------------------------------------------------------------
// Usage: one request on req (valid/ready) gives exactly one response on rsp.
// kind 0 allocates: the smallest freed ID, else the watermark (raised by one),
// else status exhausted. kind 1 frees release_id: ignored at or above the
// watermark, lowers the watermark for watermark minus one, else marks it freed.
// A request is taken while idle and then worked; its response is registered at
// the commit and valid the cycle after it. An allocate scans the freed map of
// MAP_WORDS 32-bit words (min(NUM_IDS,256)/32 rounded up, 8 by default), one
// word a cycle until it finds a set bit or reaches the last word; a free works
// on the word of release_id only. A new request is taken when the last is done.
// Reset clears the freed map and the watermark at once; a request may be sent
// on the first cycle after reset. A stalled rsp holds its response; the next
// request is still taken and waits at its commit step until the slot empties.
// ----------------------------------------------------------------------------
module lowest_free_id_allocator #(
	parameter int NUM_IDS = 256
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  lfa_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output lfa_pkg::rsp_t rsp
);
	import lfa_pkg::*;

	cmd_t cmd;
	sts_t sts;

	lfa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	lfa_datapath #(
		.NUM_IDS (NUM_IDS)
	) u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.cmd    (cmd),
		.sts    (sts),
		.rsp    (rsp)
	);

endmodule

FILE: dv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Checks the lowest free ID allocator against a predictor of its ID pool.
// Directed requests cover frees before any allocation, watermark lowering,
// duplicate frees and exhaustion of all IDs. Random allocate/free mixes with
// shifting balance follow, under random sender gaps and response stalls.
// ----------------------------------------------------------------------------
module tb;
	import lfa_pkg::*;

	localparam int NUM_IDS      = 256;
	localparam int RANDOM_REQS  = 1570;
	localparam int STALL_LIMIT  = 1000;
	localparam int DRAIN_CYCLES = 20;

	logic clk       = 1'b0;
	logic arst_n    = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	req_t req       = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	rsp_t rsp;

	bit [NUM_IDS-1:0] freed_ids     = '0;
	int               next_fresh_id = 0;
	rsp_t             pending_grants[$];
	int               mismatch_count = 0;
	int               idle_cycles    = 0;
	bit               sender_gaps    = 1'b0;
	int               burst_left     = 0;
	logic [15:0]      ready_pattern  = 16'hFFFF;
	int               pattern_age    = 0;

	lowest_free_id_allocator #(
		.NUM_IDS(NUM_IDS)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp      (rsp)
	);

	always #5 clk = ~clk;

	function automatic rsp_t grant_outcome(req_t r);
		rsp_t outcome;
		int   lowest;
		outcome = '0;
		outcome.status = ST_OK;
		lowest = -1;
		if (r.kind == KIND_ALLOC) begin
			for (int i = NUM_IDS - 1; i >= 0; i--) begin
				if (freed_ids[i]) lowest = i;
			end
			if (lowest >= 0) begin
				freed_ids[lowest] = 1'b0;
				outcome.granted_id = lowest[7:0];
			end else if (next_fresh_id < NUM_IDS) begin
				outcome.granted_id = next_fresh_id[7:0];
				next_fresh_id++;
			end else begin
				outcome.status = ST_EXHAUSTED;
			end
		end else if (int'(r.release_id) >= next_fresh_id) begin
			outcome.status = ST_IGNORED;
		end else if (int'(r.release_id) == next_fresh_id - 1) begin
			next_fresh_id--;
			freed_ids[r.release_id] = 1'b0;
		end else begin
			freed_ids[r.release_id] = 1'b1;
		end
		return outcome;
	endfunction

	task automatic send_request(input logic kind, input logic [7:0] id);
		req_t item;
		rsp_t predicted;
		item.kind = kind;
		item.release_id = id;
		if (sender_gaps && burst_left == 0) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = $urandom_range(1, 12);
		end
		req_valid <= 1'b1;
		req <= item;
		do @(posedge clk); while (!req_ready);
		predicted = grant_outcome(item);
		pending_grants = {pending_grants, predicted};
		if (burst_left > 0) burst_left--;
	endtask

	task automatic note_mismatch(input string what, input rsp_t want, input rsp_t got);
		mismatch_count++;
		if (mismatch_count <= 10) begin
			$display("%0t: %s: expected id %0d status %0d, got id %0d status %0d",
				$realtime, what, want.granted_id, want.status, got.granted_id, got.status);
		end
	endtask

	// hold responses on a rotating stall pattern, reshuffled now and then
	always @(posedge clk) begin
		if (pattern_age == 63) begin
			pattern_age <= 0;
			ready_pattern <= ($urandom_range(0, 2) == 0) ? 16'hFFFF : (16'($urandom) | 16'h0001);
		end else begin
			pattern_age <= pattern_age + 1;
			ready_pattern <= {ready_pattern[0], ready_pattern[15:1]};
		end
		rsp_ready <= ready_pattern[0];
	end

	always @(posedge clk) begin
		rsp_t want;
		if (arst_n && rsp_valid && rsp_ready) begin
			if (pending_grants.size() == 0) begin
				note_mismatch("response with no request pending", '0, rsp);
			end else begin
				want = pending_grants[0];
				pending_grants.delete(0);
				if (rsp.granted_id !== want.granted_id || rsp.status !== want.status)
					note_mismatch("wrong response", want, rsp);
			end
		end
	end

	always @(posedge clk) begin
		if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles == STALL_LIMIT) begin
			$display("FAILURE");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	task automatic test_reset_and_watermark();
		sender_gaps = 1'b0;
		send_request(KIND_FREE, 8'd0);
		send_request(KIND_FREE, 8'd255);
		repeat (4) send_request(KIND_ALLOC, 8'd0);
		send_request(KIND_FREE, 8'd200);
		send_request(KIND_FREE, 8'd2);
		send_request(KIND_FREE, 8'd3);
		send_request(KIND_FREE, 8'd2);
		send_request(KIND_ALLOC, 8'd255);
		send_request(KIND_FREE, 8'd0);
		send_request(KIND_FREE, 8'd0);
		send_request(KIND_ALLOC, 8'd0);
		send_request(KIND_FREE, 8'd2);
		send_request(KIND_FREE, 8'd1);
		send_request(KIND_FREE, 8'd0);
		send_request(KIND_FREE, 8'd0);
	endtask

	task automatic test_exhaustion();
		sender_gaps = 1'b1;
		while (!(freed_ids == '0 && next_fresh_id == NUM_IDS))
			send_request(KIND_ALLOC, 8'($urandom));
		repeat (2) send_request(KIND_ALLOC, 8'd0);
		send_request(KIND_FREE, 8'd255);
		send_request(KIND_FREE, 8'd128);
		send_request(KIND_FREE, 8'd128);
		send_request(KIND_FREE, 8'd0);
		repeat (4) send_request(KIND_ALLOC, 8'd0);
		send_request(KIND_FREE, 8'd255);
	endtask

	task automatic test_random_traffic();
		int         alloc_weight;
		int         pick;
		logic [7:0] id;
		alloc_weight = 50;
		for (int n = 0; n < RANDOM_REQS; n++) begin
			if (n % 100 == 0) begin
				alloc_weight = $urandom_range(15, 95);
				sender_gaps = ($urandom_range(0, 3) != 0);
			end
			pick = $urandom_range(0, 99);
			if (pick < alloc_weight) begin
				send_request(KIND_ALLOC, 8'($urandom));
			end else begin
				pick = $urandom_range(0, 19);
				if (next_fresh_id == 0 || pick < 3)
					id = 8'($urandom);
				else if (pick < 6)
					id = 8'(next_fresh_id - 1);
				else
					id = 8'($urandom_range(0, next_fresh_id - 1));
				send_request(KIND_FREE, id);
			end
		end
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		test_reset_and_watermark();
		test_exhaustion();
		test_random_traffic();
		req_valid <= 1'b0;
		while (pending_grants.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && pending_grants.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
